@@ sv/text_to_integer_parser_top_assert.svh @@
// Assertion macros used by the parser top module.
// Define NO_ASSERTIONS to compile every macro below to nothing.
`ifndef TEXT_TO_INTEGER_PARSER_TOP_ASSERT_SVH
`define TEXT_TO_INTEGER_PARSER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TTIP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttip assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TTIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttip assertion failed");

`else

`define TTIP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TTIP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/ttip_pkg.sv @@
package ttip_pkg;

   localparam int CODE_UNIT_W = 16;
   localparam int VALUE_W     = 32;
   localparam int DIGIT_W     = 4;

   // Character codes the parser reacts to.
   localparam logic [CODE_UNIT_W-1:0] CH_NUL     = 16'h0000;
   localparam logic [CODE_UNIT_W-1:0] CH_SPACE   = 16'h0020;
   localparam logic [CODE_UNIT_W-1:0] CH_MINUS   = 16'h002D;
   localparam logic [CODE_UNIT_W-1:0] CH_ZERO    = 16'h0030;
   localparam logic [CODE_UNIT_W-1:0] CH_NINE    = 16'h0039;
   localparam logic [CODE_UNIT_W-1:0] CH_UPPER_A = 16'h0041;
   localparam logic [CODE_UNIT_W-1:0] CH_UPPER_F = 16'h0046;
   localparam logic [CODE_UNIT_W-1:0] CH_LOWER_A = 16'h0061;
   localparam logic [CODE_UNIT_W-1:0] CH_LOWER_F = 16'h0066;
   localparam logic [CODE_UNIT_W-1:0] CH_UPPER_X = 16'h0058;
   localparam logic [CODE_UNIT_W-1:0] CH_LOWER_X = 16'h0078;

   // Value of the letter A as a digit; letters B to F follow it.
   localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'hA;

   typedef enum logic [3:0] {
      PH_START  = 4'b0001,
      PH_ZERO   = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [VALUE_W-1:0] accumulator;
      logic               negative;
      logic               hex_mode;
   } parse_state_type;

   localparam parse_state_type PARSE_CLEAR = '{
      phase:       PH_START,
      accumulator: '0,
      negative:    1'b0,
      hex_mode:    1'b0
   };

endpackage

@@ sv/ttip_req_if.sv @@
interface ttip_req_if;
   import ttip_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CODE_UNIT_W-1:0] code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink (input valid, input code_unit, output ready);
endinterface

@@ sv/ttip_rsp_if.sv @@
interface ttip_rsp_if;
   import ttip_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

@@ sv/ttip_csr_if.sv @@
interface ttip_csr_if;
   logic valid;
   logic ready;
   logic allow_hex;

   modport source (output valid, output allow_hex, input ready);
   modport sink (input valid, input allow_hex, output ready);
endinterface

@@ sv/ttip_step.sv @@
module ttip_step (
   input  ttip_pkg::parse_state_type          state_cur,
   input  logic [ttip_pkg::CODE_UNIT_W-1:0]   code_unit,
   input  logic                               allow_hex,
   output ttip_pkg::parse_state_type          state_nxt,
   output logic [ttip_pkg::VALUE_W-1:0]       value
);
   import ttip_pkg::*;

   logic               is_dec;
   logic               is_upper;
   logic               is_lower;
   logic               is_digit;
   logic [DIGIT_W-1:0] digit;
   logic [VALUE_W-1:0] acc_scaled;
   logic [VALUE_W-1:0] acc_digit;
   parse_state_type    after_digit;

   // Digit decode; letters only count once a hex prefix has been seen.
   always_comb begin
      is_dec   = (code_unit >= CH_ZERO) && (code_unit <= CH_NINE);
      is_upper = state_cur.hex_mode && (code_unit >= CH_UPPER_A) && (code_unit <= CH_UPPER_F);
      is_lower = state_cur.hex_mode && (code_unit >= CH_LOWER_A) && (code_unit <= CH_LOWER_F);
      is_digit = is_dec || is_upper || is_lower;
      if (is_upper) begin
         digit = DIGIT_W'(code_unit - CH_UPPER_A) + DIGIT_TEN;
      end else if (is_lower) begin
         digit = DIGIT_W'(code_unit - CH_LOWER_A) + DIGIT_TEN;
      end else begin
         digit = DIGIT_W'(code_unit - CH_ZERO);
      end
   end

   // Times sixteen is a shift; times ten is eight plus two.
   always_comb begin
      if (state_cur.hex_mode) begin
         acc_scaled = {state_cur.accumulator[VALUE_W-5:0], 4'b0000};
      end else begin
         acc_scaled = {state_cur.accumulator[VALUE_W-4:0], 3'b000}
                    + {state_cur.accumulator[VALUE_W-2:0], 1'b0};
      end
      acc_digit = acc_scaled + {{(VALUE_W-DIGIT_W){1'b0}}, digit};
   end

   // State after feeding the character as a digit; a non-digit ends the number.
   always_comb begin
      after_digit = state_cur;
      if (is_digit) begin
         after_digit.accumulator = acc_digit;
         after_digit.phase       = PH_DIGITS;
      end else begin
         after_digit.phase = PH_DONE;
      end
   end

   assign value = state_cur.negative ? (VALUE_W'(0) - state_cur.accumulator)
                                     : state_cur.accumulator;

   always_comb begin
      state_nxt = state_cur;
      if (code_unit == CH_NUL) begin
         state_nxt = PARSE_CLEAR;
      end else begin
         case (state_cur.phase)
            PH_START: begin
               if (!state_cur.negative && (code_unit == CH_SPACE)) begin
                  state_nxt = state_cur;
               end else if (!state_cur.negative && (code_unit == CH_MINUS)) begin
                  state_nxt.negative = 1'b1;
               end else if (allow_hex && (code_unit == CH_ZERO)) begin
                  state_nxt.phase = PH_ZERO;
               end else begin
                  state_nxt = after_digit;
               end
            end
            PH_ZERO: begin
               if ((code_unit == CH_LOWER_X) || (code_unit == CH_UPPER_X)) begin
                  state_nxt.hex_mode = 1'b1;
                  state_nxt.negative = 1'b0;
                  state_nxt.phase    = PH_DIGITS;
               end else begin
                  state_nxt = after_digit;
               end
            end
            PH_DIGITS: begin
               state_nxt = after_digit;
            end
            default: begin
               state_nxt = state_cur;
            end
         endcase
      end
   end
endmodule

@@ sv/text_to_integer_parser_top.sv @@
// Channel   Direction  Payload                  Transfer when
// req_chan  in         code_unit [15:0]         valid && ready
// rsp_chan  out        value [31:0] signed      valid && ready
// csr_chan  in         allow_hex [0]            valid && ready (always ready)
//
// Every character is registered in the input register, and the step logic
// writes the result register when a NUL leaves it, so a result is valid once
// its NUL has passed through the input register, and it can then be taken.
// One character is taken per cycle; the only thing that stalls the input is a
// NUL that meets a full result register whose result is not being taken.
// Ordinary characters keep flowing while a result waits at the output.
// Reset is synchronous and active high; it clears the parse state, the control
// valids and allow_hex, and no clearing pass follows it.
module text_to_integer_parser_top (
   input logic  clock,
   input logic  reset,
   ttip_req_if.sink   req_chan,
   ttip_rsp_if.source rsp_chan,
   ttip_csr_if.sink   csr_chan
);
   import ttip_pkg::*;

`include "text_to_integer_parser_top_assert.svh"

   // Configuration register. Writes are only to be made while the parser is idle;
   // the block itself does not enforce this. The register is always ready.
   logic allow_hex_ff;
   logic allow_hex_in;

   // Input register stage holding one character.
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [CODE_UNIT_W-1:0] s1_code_unit_ff;
   logic [CODE_UNIT_W-1:0] s1_code_unit_in;

   // Running parse state.
   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type state_step;

   // Result register.
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [VALUE_W-1:0] rsp_value_in;
   logic [VALUE_W-1:0] step_value;

   logic req_take;
   logic s1_is_nul;
   logic rsp_free;
   logic s1_go;
   logic rsp_load;

   assign csr_chan.ready = 1'b1;
   assign allow_hex_in   = (csr_chan.valid) ? csr_chan.allow_hex : allow_hex_ff;

   // A character in the input stage moves on unless it is a NUL whose result
   // has nowhere to go this cycle.
   assign s1_is_nul = (s1_code_unit_ff == CH_NUL);
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign s1_go     = s1_valid_ff && (!s1_is_nul || rsp_free);
   assign rsp_load  = s1_go && s1_is_nul;

   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign s1_valid_in     = req_take || (s1_valid_ff && !s1_go);
   assign s1_code_unit_in = req_take ? req_chan.code_unit : s1_code_unit_ff;

   ttip_step u_step (
      .state_cur (state_ff),
      .code_unit (s1_code_unit_ff),
      .allow_hex (allow_hex_ff),
      .state_nxt (state_step),
      .value     (step_value)
   );

   assign state_in = s1_go ? state_step : state_ff;

   // The result register fills on a NUL and empties when the result is taken.
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_value_in = rsp_load ? step_value : rsp_value_ff;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.value = $signed(rsp_value_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_hex_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         state_ff     <= PARSE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         allow_hex_ff <= allow_hex_in;
         s1_valid_ff  <= s1_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_code_unit_ff <= s1_code_unit_in;
      rsp_value_ff    <= rsp_value_in;
   end

   // A NUL that leaves the input stage leaves the parser in its start state.
   `TTIP_ASSERT_NEXT(a_nul_clears, clock, reset, rsp_load, (state_ff == PARSE_CLEAR))

   // A waiting result is never overwritten by the next NUL.
   `TTIP_ASSERT_IMPLIES(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_chan.ready, !rsp_load)

   // The hex prefix cancels the sign, so both flags are never set together.
   `TTIP_ASSERT_IMPLIES(a_sign_hex, clock, reset, state_ff.negative, !state_ff.hex_mode)

   // Hex mode is entered only by a prefix, which puts the parser among digits.
   `TTIP_ASSERT_IMPLIES(a_hex_phase, clock, reset, state_ff.hex_mode, (state_ff.phase == PH_DIGITS) || (state_ff.phase == PH_DONE))

   // Ordinary characters never block the input stage.
   `TTIP_ASSERT_IMPLIES(a_char_flows, clock, reset, s1_valid_ff && !s1_is_nul, req_chan.ready)
endmodule
